[rtl/core/tbd_pkg.sv]
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types and constants for the timebase / decrementer timer core.
// ----------------------------------------------------------------------------
package tbd_pkg;

  // Field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned CycW    = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned TbW     = 64;
  localparam int unsigned FracW   = 2;
  localparam int unsigned TbHiW   = 24;
  // timebase bit positions
  localparam int unsigned LoLsb   = FracW;               // bits 33..2
  localparam int unsigned HiLsb   = FracW + WordW;       // bits 63..34
  localparam int unsigned WrapLsb = 56 + FracW;          // limit 2^58
  localparam int unsigned HiWrW   = TbW - HiLsb;         // 30 bits kept on write high
  localparam int unsigned AmtW    = CycW - FracW + 1;    // cycles/4 plus one

  // Item kinds
  typedef enum logic [KindW-1:0] {
    KIND_TICK       = 3'd0,
    KIND_RD_TB_LO   = 3'd1,
    KIND_RD_TB_HI   = 3'd2,
    KIND_WR_TB_LO   = 3'd3,
    KIND_WR_TB_HI   = 3'd4,
    KIND_WR_DEC     = 3'd5,
    KIND_RD_DEC_ACK = 3'd6
  } kind_t;

  // One input word
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CycW-1:0]  cycle_count;
    logic [WordW-1:0] write_value;
  } item_t;

  // One result word
  typedef struct packed {
    logic [WordW-1:0] read_value;
    logic             expired;
  } result_t;

endpackage

[rtl/core/tbd_in_reg.sv]
// ----------------------------------------------------------------------------
// tbd_in_reg
// Input register: captures one word and holds it until execution takes it.
// ----------------------------------------------------------------------------
module tbd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tbd_pkg::item_t in_item,
  input  logic           take,        // execute stage consumes the held word
  output logic           vld,
  output tbd_pkg::item_t item
);
  import tbd_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r, item_nxt;

  // register is free when empty or being drained this cycle
  assign in_stall = vld_r && !take;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (!in_stall) begin
      vld_nxt  = in_valid;
      item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

[rtl/core/tbd_exec.sv]
// ----------------------------------------------------------------------------
// tbd_exec
// Timer state (timebase, decrementer, expired flag, enable) and the
// single-pass update for one word.
// ----------------------------------------------------------------------------
module tbd_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_dec_en,
  input  logic             fire,
  input  tbd_pkg::item_t   item,
  output tbd_pkg::result_t result
);
  import tbd_pkg::*;

  logic [TbW-1:0]   time_base_r, time_base_nxt;
  logic [WordW-1:0] down_counter_r, down_counter_nxt;
  logic             expired_flag_r, expired_flag_nxt;
  logic             dec_en_r;

  logic [TbW-1:0]   tb_sum;
  logic [TbW-1:0]   tb_tick;
  logic [AmtW-1:0]  amount;
  logic [WordW-1:0] rd_val;
  kind_t            kind;

  assign kind = kind_t'(item.kind);

  // tick: add cycles, drop 2^56 units once past the limit (only top bits move)
  always_comb begin
    tb_sum  = time_base_r + {{(TbW-CycW){1'b0}}, item.cycle_count};
    tb_tick = tb_sum;
    if (|tb_sum[TbW-1:WrapLsb]) begin
      tb_tick[TbW-1:WrapLsb] = tb_sum[TbW-1:WrapLsb] - 1'b1;
    end
    amount = {1'b0, item.cycle_count[CycW-1:FracW]}
           + {{(AmtW-1){1'b0}}, |tb_tick[FracW-1:0]};
  end

  // next state and read word
  always_comb begin
    time_base_nxt    = time_base_r;
    down_counter_nxt = down_counter_r;
    expired_flag_nxt = expired_flag_r;
    rd_val           = '0;
    case (kind)
      KIND_TICK: begin
        time_base_nxt = tb_tick;
        if (dec_en_r) begin
          down_counter_nxt = down_counter_r - {{(WordW-AmtW){1'b0}}, amount};
          if ({{(WordW-AmtW){1'b0}}, amount} > down_counter_r) begin
            expired_flag_nxt = 1'b1;
          end
        end
      end
      KIND_RD_TB_LO: begin
        rd_val = time_base_r[HiLsb-1:LoLsb];
      end
      KIND_RD_TB_HI: begin
        rd_val = {{(WordW-TbHiW){1'b0}}, time_base_r[HiLsb+TbHiW-1:HiLsb]};
      end
      KIND_WR_TB_LO: begin
        time_base_nxt[HiLsb-1:LoLsb] = item.write_value;
      end
      KIND_WR_TB_HI: begin
        time_base_nxt[TbW-1:HiLsb] = item.write_value[HiWrW-1:0];
      end
      KIND_WR_DEC: begin
        down_counter_nxt = item.write_value;
      end
      KIND_RD_DEC_ACK: begin
        rd_val           = down_counter_r;
        expired_flag_nxt = 1'b0;
      end
      default: begin
        rd_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_base_r    <= '0;
      down_counter_r <= '0;
      expired_flag_r <= 1'b0;
      dec_en_r       <= 1'b1;
    end else begin
      if (fire) begin
        time_base_r    <= time_base_nxt;
        down_counter_r <= down_counter_nxt;
        expired_flag_r <= expired_flag_nxt;
      end
      if (cfg_we) begin
        dec_en_r <= cfg_dec_en;
      end
    end
  end

  assign result.read_value = rd_val;
  assign result.expired    = expired_flag_nxt;

`ifndef SYNTH
  // acknowledge always leaves the flag clear
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (kind == KIND_RD_DEC_ACK) |=> !expired_flag_r)
    else $error("expired flag not cleared by acknowledge");

  // no accepted word, no timer state change
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(time_base_r) && $stable(down_counter_r)
              && $stable(expired_flag_r))
    else $error("timer state changed without a word");

  // a tick from below the limit stays below the limit
  a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (kind == KIND_TICK) && (time_base_r[TbW-1:WrapLsb] == '0)
    |=> time_base_r[TbW-1:WrapLsb] == '0)
    else $error("timebase wrap left value above limit");

  // flag only rises on a tick
  a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(expired_flag_r) |-> $past(fire) && ($past(kind) == KIND_TICK))
    else $error("expired flag set outside a tick");
`endif

endmodule

[rtl/core/tbd_out_reg.sv]
// ----------------------------------------------------------------------------
// tbd_out_reg
// Result register: holds one finished word until the receiver takes it.
// ----------------------------------------------------------------------------
module tbd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tbd_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output tbd_pkg::result_t res_out
);
  import tbd_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r, res_nxt;

  // free when empty or being taken this cycle
  assign can_load = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (can_load) begin
      vld_nxt = load;
      res_nxt = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule

[rtl/core/timebase_decrementer_timer_core.sv]
// ----------------------------------------------------------------------------
// timebase_decrementer_timer_core
// Timebase counter with two fraction bits, 32-bit decrementer and sticky
// expired flag; one result word per input word.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    in_kind, in_cycle_count, in_write_value
//   out      out  out_valid/out_stall  out_read_value, out_expired
//   cfg      in   cfg_valid/cfg_ready  cfg_decrementer_enable
//
// out_valid rises once an accepted word has passed the input register and
// been loaded into the result register; one word per cycle sustained while
// out is not stalled, with the single add/compare/subtract pass between the
// input and result registers. Reset clears timebase, decrementer and flag
// and sets the decrementer enable. A stall on out backs up through the input
// register to in_stall in the same cycle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module timebase_decrementer_timer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tbd_pkg::KindW-1:0]   in_kind,
  input  logic [tbd_pkg::CycW-1:0]    in_cycle_count,
  input  logic [tbd_pkg::WordW-1:0]   in_write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbd_pkg::WordW-1:0]   out_read_value,
  output logic                        out_expired,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_decrementer_enable
);
  import tbd_pkg::*;

  item_t   in_item, ex_item;
  result_t ex_res, out_res;
  logic    ex_vld, can_load, fire;

  assign in_item.kind        = in_kind;
  assign in_item.cycle_count = in_cycle_count;
  assign in_item.write_value = in_write_value;

  // execute when a word is held and the result register has room
  assign fire      = ex_vld && can_load;
  assign cfg_ready = 1'b1;

  tbd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (can_load),
    .vld      (ex_vld),
    .item     (ex_item)
  );

  tbd_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_dec_en (cfg_decrementer_enable),
    .fire       (fire),
    .item       (ex_item),
    .result     (ex_res)
  );

  tbd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ex_vld),
    .res_in    (ex_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign out_read_value = out_res.read_value;
  assign out_expired    = out_res.expired;

endmodule

[tb/sv/tb_timebase_decrementer_timer_core.sv]
// ----------------------------------------------------------------------------
// tb_timebase_decrementer_timer_core
// Self-checking bench for the timebase / decrementer timer core. Words go in
// through a bursty sender and results come out under a patterned stall. A
// scoreboard class keeps its own timebase, decrementer, flag and enable,
// predicts one result per accepted word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_timebase_decrementer_timer_core;
  import tbd_pkg::*;

  localparam logic [KindW-1:0] KIND_UNUSED = 3'd7;
  localparam logic [WordW-1:0] HI_TOP      = 32'h00FF_FFFF;
  localparam int unsigned      MAX_REPORTS = 10;

  // Timer state tracker: predicts results and holds what is still owed
  class timer_tracker;
    logic [TbW-1:0]   time_base;
    logic [WordW-1:0] down_count;
    logic             expired;
    logic             count_enable;
    result_t          owed_results[$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      ticks;
    int unsigned      tb_wraps;
    int unsigned      underflows;

    function new();
      time_base    = '0;
      down_count   = '0;
      expired      = 1'b0;
      count_enable = 1'b1;
    endfunction

    // Apply one accepted word and queue its result
    function void note_word(logic [KindW-1:0] kind, logic [CycW-1:0] cyc,
                            logic [WordW-1:0] wv);
      result_t        res;
      logic [TbW-1:0] sum;
      logic [WordW-1:0] amount;
      res.read_value = '0;
      case (kind)
        KIND_TICK: begin
          ticks++;
          sum = time_base + TbW'(cyc);
          // past 2^58: take 2^56 off the integer part, fraction stays
          if (sum >= (64'd1 << WrapLsb)) begin
            sum = sum - (64'd1 << WrapLsb);
            tb_wraps++;
          end
          time_base = sum;
          if (count_enable) begin
            amount = WordW'(cyc[CycW-1:FracW]) + ((sum[FracW-1:0] != '0) ? 1 : 0);
            if (amount > down_count) begin
              expired = 1'b1;
              underflows++;
            end
            down_count = down_count - amount;
          end
        end
        KIND_RD_TB_LO:   res.read_value = time_base[LoLsb +: WordW];
        KIND_RD_TB_HI:   res.read_value = WordW'(time_base[HiLsb +: TbHiW]);
        KIND_WR_TB_LO:   time_base[LoLsb +: WordW] = wv;
        KIND_WR_TB_HI:   time_base[HiLsb +: HiWrW] = wv[HiWrW-1:0];
        KIND_WR_DEC:     down_count = wv;
        KIND_RD_DEC_ACK: begin
          res.read_value = down_count;
          expired = 1'b0;
        end
        default: ;
      endcase
      res.expired = expired;
      owed_results.push_back(res);
    endfunction

    function void report(string what, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (mismatches < MAX_REPORTS)
        $display("mismatch on result %0d: %s expected 0x%08h got 0x%08h",
                 results_seen, what, want, got);
      mismatches++;
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_word(logic [WordW-1:0] rv, logic ex);
      result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        report("unexpected result, read_value", '0, rv);
        return;
      end
      want = owed_results.pop_front();
      if (rv !== want.read_value) report("read_value", want.read_value, rv);
      if (ex !== want.expired)    report("expired", WordW'(want.expired), WordW'(ex));
    endfunction
  endclass

  logic             clk;
  logic             rst_n                  = 1'b0;
  logic             in_valid               = 1'b0;
  logic             in_stall;
  logic [KindW-1:0] in_kind                = '0;
  logic [CycW-1:0]  in_cycle_count         = '0;
  logic [WordW-1:0] in_write_value         = '0;
  logic             out_valid;
  logic             out_stall              = 1'b0;
  logic [WordW-1:0] out_read_value;
  logic             out_expired;
  logic             cfg_valid              = 1'b0;
  logic             cfg_ready;
  logic             cfg_decrementer_enable = 1'b0;

  timer_tracker tracker = new();
  int unsigned  words_sent;
  int unsigned  burst_left;
  int unsigned  enable_writes;
  int unsigned  stall_mode;
  int unsigned  stall_count;

  timebase_decrementer_timer_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_cycle_count         (in_cycle_count),
    .in_write_value         (in_write_value),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_value         (out_read_value),
    .out_expired            (out_expired),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_decrementer_enable (cfg_decrementer_enable)
  );

  // Clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result stall: switches between four randomly chosen stall modes
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_count = 0;
      stall_mode  = 0;
    end else begin
      if (stall_count == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_count = $urandom_range(16, 96);
      end else begin
        stall_count = stall_count - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ((stall_count % 8) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      tracker.check_word(out_read_value, out_expired);
  end

  // Random cycle count over the full field
  function automatic logic [CycW-1:0] rand_cyc();
    return CycW'($urandom_range(0, 65535));
  endfunction

  // Send one word; held until accepted, then maybe a gap
  task automatic send_word(input logic [KindW-1:0] kind, input logic [CycW-1:0] cyc,
                           input logic [WordW-1:0] wv);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_cycle_count <= cyc;
    in_write_value <= wv;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_word(kind, cyc, wv);
    if (kind != KIND_UNUSED) words_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Enable write, only once every owed result is back
  task automatic write_enable(input logic en);
    in_valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk);
    cfg_valid              <= 1'b1;
    cfg_decrementer_enable <= en;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.count_enable = en;
    enable_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random part: mostly short well-formed sequences, some noise
  task automatic run_phase(input int unsigned words);
    int unsigned goal;
    int unsigned n;
    logic [WordW-1:0] v;
    goal = words_sent + words;
    while (words_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // load the decrementer low, tick it through zero, read and ack
          v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 400);
          send_word(KIND_WR_DEC, rand_cyc(), v);
          n = $urandom_range(1, 6);
          repeat (n)
            send_word(KIND_TICK,
                      CycW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 65535)),
                      $urandom());
          send_word(KIND_RD_DEC_ACK, rand_cyc(), $urandom());
        end
        4, 5: begin
          // park the timebase just under the limit (or far above) and tick
          case ($urandom_range(0, 2))
            0:       v = HI_TOP;
            1:       v = HI_TOP - $urandom_range(0, 3);
            default: v = $urandom();
          endcase
          send_word(KIND_WR_TB_HI, rand_cyc(), v);
          send_word(KIND_WR_TB_LO, rand_cyc(),
                    32'hFFFF_FFFF - $urandom_range(0, 40000));
          n = $urandom_range(1, 4);
          repeat (n) send_word(KIND_TICK, rand_cyc(), $urandom());
          send_word(KIND_RD_TB_HI, rand_cyc(), $urandom());
          send_word(KIND_RD_TB_LO, rand_cyc(), $urandom());
        end
        6, 7: send_word(KindW'($urandom_range(KIND_TICK, KIND_RD_DEC_ACK)),
                        rand_cyc(), $urandom());
        8:    send_word(KIND_UNUSED, rand_cyc(), $urandom());
        default: begin
          send_word(KIND_RD_TB_LO, rand_cyc(), $urandom());
          send_word(KIND_RD_TB_HI, rand_cyc(), $urandom());
          send_word(KIND_RD_DEC_ACK, rand_cyc(), $urandom());
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    int unsigned w;
    burst_left = 4;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_enable(1'b1);

    // reset values, then the decrementer through zero from zero
    send_word(KIND_RD_TB_LO, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(KIND_RD_TB_HI, 16'h0000, 32'h0000_0000);
    send_word(KIND_RD_DEC_ACK, rand_cyc(), $urandom());
    send_word(KIND_TICK, 16'h0000, $urandom());
    send_word(KIND_TICK, 16'h0001, $urandom());      // fraction adds one unit
    send_word(KIND_RD_DEC_ACK, rand_cyc(), $urandom());
    send_word(KIND_WR_DEC, rand_cyc(), 32'h0000_0000);
    send_word(KIND_TICK, 16'hFFFF, $urandom());
    send_word(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF); // flag must stay set
    send_word(KIND_RD_DEC_ACK, rand_cyc(), $urandom());
    send_word(KIND_WR_DEC, rand_cyc(), 32'hFFFF_FFFF);
    send_word(KIND_TICK, 16'h0004, $urandom());
    // write high drops its top two bits; timebase far above the limit
    send_word(KIND_WR_TB_HI, rand_cyc(), 32'hFFFF_FFFF);
    send_word(KIND_WR_TB_LO, rand_cyc(), 32'hFFFF_FFFF);
    send_word(KIND_RD_TB_HI, rand_cyc(), $urandom());
    send_word(KIND_RD_TB_LO, rand_cyc(), $urandom());
    send_word(KIND_TICK, 16'hFFFF, $urandom());      // 64-bit wrap
    send_word(KIND_RD_TB_HI, rand_cyc(), $urandom());
    send_word(KIND_RD_TB_LO, rand_cyc(), $urandom());
    // cross the limit exactly, fraction kept
    send_word(KIND_WR_TB_HI, rand_cyc(), HI_TOP);
    send_word(KIND_WR_TB_LO, rand_cyc(), 32'hFFFF_FFFF);
    send_word(KIND_TICK, 16'h0007, $urandom());
    send_word(KIND_RD_TB_HI, rand_cyc(), $urandom());
    send_word(KIND_RD_TB_LO, rand_cyc(), $urandom());
    send_word(KIND_WR_DEC, rand_cyc(), 32'h0000_0000);

    // random phases over both enable settings
    write_enable(1'b0);
    run_phase(150);
    write_enable(1'b1);
    run_phase(150);
    write_enable(1'b0);
    run_phase(150);
    write_enable(1'b1);
    run_phase(150);
    write_enable(1'($urandom_range(0, 1)));
    run_phase(150);
    write_enable(1'($urandom_range(0, 1)));
    run_phase(150);

    // drain
    in_valid <= 1'b0;
    w = 0;
    while (tracker.owed_results.size() != 0 && w < 5000) begin
      @(negedge clk);
      w++;
    end
    repeat (10) @(negedge clk);
    if (tracker.owed_results.size() != 0)
      $display("%0d results never arrived", tracker.owed_results.size());

    $display("covered %0d words: %0d ticks, %0d timebase wraps, %0d decrementer underflows",
             words_sent, tracker.ticks, tracker.tb_wraps, tracker.underflows);
    $display("%0d enable writes, %0d results checked, %0d mismatches",
             enable_writes, tracker.results_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
